// ----- rtl/sdtq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the deadline timer queue
// Operation codes, result codes and the command beat passed front to back.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   // Request modes as they arrive on the input channel.
   localparam logic [2:0] MODE_ARM    = 3'd0;
   localparam logic [2:0] MODE_DELETE = 3'd1;
   localparam logic [2:0] MODE_QUERY  = 3'd2;
   localparam logic [2:0] MODE_TICK   = 3'd3;
   localparam logic [2:0] MODE_CHECK  = 3'd4;

   // Result kinds.
   localparam logic [2:0] RES_ACK     = 3'd0;
   localparam logic [2:0] RES_QUERY   = 3'd1;
   localparam logic [2:0] RES_FIRED   = 3'd2;
   localparam logic [2:0] RES_NONE    = 3'd3;
   localparam logic [2:0] RES_CHECK   = 3'd4;

   // Classified operations handed to the back end.
   localparam logic [2:0] OP_NOP      = 3'd0;
   localparam logic [2:0] OP_ARM      = 3'd1;
   localparam logic [2:0] OP_DELETE   = 3'd2;
   localparam logic [2:0] OP_QUERY    = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;
   localparam logic [2:0] OP_CHECK    = 3'd5;

   localparam int DEFAULT_SLOT_COUNT = 16;
   localparam int MASK_WIDTH         = 16;
   localparam int TICK_LIMIT         = 16;
   localparam int TICK_CNT_W         = $clog2(TICK_LIMIT + 1);

   typedef struct packed {
      logic [2:0]         op;
      logic               slot_ok;
      logic [3:0]         slot_id;
      logic               clock_kind;
      logic signed [63:0] time_value;
   } cmd_type;

endpackage

// ----- rtl/sdtq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_front: request intake and command queue
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sdtq_front #(
   parameter int SLOT_COUNT = sdtq_pkg::DEFAULT_SLOT_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [3:0]         req_slot_id,
   input  logic               req_clock_kind,
   input  logic signed [63:0] req_time_value,
   output logic               q_valid,
   output sdtq_pkg::cmd_type  q_data,
   input  logic               q_pop
);
   import sdtq_pkg::*;

   cmd_type    cmd;
   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Classify the incoming beat.
   always_comb begin
      cmd.slot_ok    = 32'(req_slot_id) < SLOT_COUNT;
      cmd.slot_id    = req_slot_id;
      cmd.clock_kind = req_clock_kind;
      cmd.time_value = req_time_value;
      unique case (req_mode)
         MODE_ARM:    cmd.op = OP_ARM;
         MODE_DELETE: cmd.op = OP_DELETE;
         MODE_QUERY:  cmd.op = OP_QUERY;
         MODE_TICK:   cmd.op = OP_TICK;
         MODE_CHECK:  cmd.op = OP_CHECK;
         default:     cmd.op = OP_NOP;
      endcase
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = entry_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ----- rtl/sdtq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_back: linked-list engine of the timer queue
// Walks the sorted lists one entry a cycle to arm, delete, fire and report.
// ----------------------------------------------------------------------------
module sdtq_back #(
   parameter int SLOT_COUNT = sdtq_pkg::DEFAULT_SLOT_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sdtq_pkg::MASK_WIDTH-1:0]     slot_clock_mask,
   input  logic                                q_valid,
   input  sdtq_pkg::cmd_type                   q_data,
   output logic                                q_pop,
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_result_kind,
   output logic [3:0]                          rsp_fired_slot,
   output logic                                rsp_flag,
   output logic signed [63:0]                  rsp_stored_deadline,
   output logic                                rsp_last
);
   import sdtq_pkg::*;

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LW = $clog2(SLOT_COUNT + 1);
   localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_UNL  = 3'd2;
   localparam logic [2:0] S_INS  = 3'd3;
   localparam logic [2:0] S_TICK = 3'd4;

   // List storage.
   logic signed [63:0] dl_ff  [SLOT_COUNT];
   logic [LW-1:0]      nxt_ff [SLOT_COUNT];
   logic [LW-1:0]      head_ff [2];
   logic [SLOT_COUNT-1:0] linked_ff;
   logic [SLOT_COUNT-1:0] inlist_ff;

   // Control registers.
   logic [2:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [LW-1:0]         cur_ff, cur_in;
   logic [LW-1:0]         prev_ff, prev_in;
   logic [TICK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pend_v_ff, pend_v_in;
   logic [3:0]            pend_slot_ff, pend_slot_in;
   logic signed [63:0]    pend_dl_ff, pend_dl_in;

   // Result registers.
   logic               strobe_ff, strobe_in;
   logic [2:0]         kind_ff, kind_in;
   logic [3:0]         slot_ff, slot_in;
   logic               flag_ff, flag_in;
   logic signed [63:0] dlo_ff, dlo_in;
   logic               last_ff, last_in;

   // Write controls of the storage.
   logic               dl_we;
   logic               nxa_we, nxb_we;
   logic [IW-1:0]      nxa_idx, nxb_idx;
   logic [LW-1:0]      nxa_d, nxb_d;
   logic               hd_we, hd_sel;
   logic [LW-1:0]      hd_d;
   logic               lk_we, lk_val, il_we, il_val;
   logic [IW-1:0]      lk_idx;

   // Shared read port.
   logic [LW-1:0]      rd_link;
   logic [IW-1:0]      rd_idx;
   logic               rd_ok;
   logic signed [63:0] rd_dl;
   logic [LW-1:0]      rd_nxt;
   logic               due;
   logic [IW-1:0]      sidx;
   logic [LW-1:0]      slink;
   logic               mbit;

   assign sidx  = IW'(cmd_ff.slot_id);
   assign slink = LW'(cmd_ff.slot_id);
   assign mbit  = slot_clock_mask[cmd_ff.slot_id];

   // Read address selection: one entry of the lists is looked at per cycle.
   always_comb begin
      if (state_ff == S_UNL || state_ff == S_INS) begin
         rd_link = cur_ff;
      end else begin
         rd_link = head_ff[cmd_ff.clock_kind];
      end
      rd_ok = (rd_link < NIL);
      if (state_ff == S_DISP && cmd_ff.op == OP_QUERY) begin
         rd_idx = sidx;
      end else begin
         rd_idx = IW'(rd_link);
      end
      rd_dl  = dl_ff[rd_idx];
      rd_nxt = nxt_ff[rd_idx];
      due    = rd_ok && !(rd_dl > cmd_ff.time_value);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_dl_in   = pend_dl_ff;
      q_pop        = 1'b0;
      strobe_in    = 1'b0;
      kind_in      = RES_ACK;
      slot_in      = 4'd0;
      flag_in      = 1'b0;
      dlo_in       = 64'sd0;
      last_in      = 1'b1;
      dl_we        = 1'b0;
      nxa_we       = 1'b0;
      nxa_idx      = IW'(prev_ff);
      nxa_d        = NIL;
      nxb_we       = 1'b0;
      nxb_idx      = sidx;
      nxb_d        = NIL;
      hd_we        = 1'b0;
      hd_sel       = cmd_ff.clock_kind;
      hd_d         = NIL;
      lk_we        = 1'b0;
      lk_idx       = sidx;
      lk_val       = 1'b0;
      il_we        = 1'b0;
      il_val       = mbit;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            prev_in = NIL;
            cnt_in  = '0;
            pend_v_in = 1'b0;
            state_in  = S_IDLE;
            unique case (cmd_ff.op)
               OP_ARM: begin
                  if (!cmd_ff.slot_ok) begin
                     strobe_in = 1'b1;
                  end else if (linked_ff[sidx]) begin
                     cur_in   = head_ff[inlist_ff[sidx]];
                     state_in = S_UNL;
                  end else begin
                     cur_in   = head_ff[mbit];
                     state_in = S_INS;
                  end
               end
               OP_DELETE: begin
                  if (cmd_ff.slot_ok && linked_ff[sidx]) begin
                     cur_in   = head_ff[inlist_ff[sidx]];
                     state_in = S_UNL;
                  end else begin
                     strobe_in = 1'b1;
                  end
               end
               OP_QUERY: begin
                  strobe_in = 1'b1;
                  kind_in   = RES_QUERY;
                  slot_in   = cmd_ff.slot_id;
                  if (cmd_ff.slot_ok) begin
                     flag_in = linked_ff[sidx];
                     dlo_in  = rd_dl;
                  end
               end
               OP_CHECK: begin
                  strobe_in = 1'b1;
                  kind_in   = RES_CHECK;
                  flag_in   = due;
               end
               OP_TICK: begin
                  state_in = S_TICK;
               end
               default: begin
                  strobe_in = 1'b1;
               end
            endcase
         end

         // Find the slot's predecessor and splice it out.
         S_UNL: begin
            if (cur_ff == slink) begin
               if (prev_ff == NIL) begin
                  hd_we  = 1'b1;
                  hd_sel = inlist_ff[sidx];
                  hd_d   = rd_nxt;
               end else begin
                  nxa_we = 1'b1;
                  nxa_d  = rd_nxt;
               end
               nxb_we   = 1'b1;
               lk_we    = 1'b1;
               state_in = S_DISP;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_nxt;
            end
         end

         // Walk to the first later deadline and link the slot before it.
         S_INS: begin
            if (!rd_ok || rd_dl > cmd_ff.time_value) begin
               dl_we  = 1'b1;
               nxb_we = 1'b1;
               nxb_d  = cur_ff;
               if (prev_ff == NIL) begin
                  hd_we  = 1'b1;
                  hd_sel = mbit;
                  hd_d   = slink;
               end else begin
                  nxa_we = 1'b1;
                  nxa_d  = slink;
               end
               lk_we     = 1'b1;
               lk_val    = 1'b1;
               il_we     = 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_nxt;
            end
         end

         // Pop due heads; each fired beat is held in the pend registers until the
         // next pop or the end of the tick, so that the final one can be marked.
         S_TICK: begin
            if (due && cnt_ff < TICK_CNT_W'(TICK_LIMIT)) begin
               hd_we   = 1'b1;
               hd_d    = rd_nxt;
               nxb_we  = 1'b1;
               nxb_idx = rd_idx;
               lk_we   = 1'b1;
               lk_idx  = rd_idx;
               if (pend_v_ff) begin
                  strobe_in = 1'b1;
                  kind_in   = RES_FIRED;
                  slot_in   = pend_slot_ff;
                  dlo_in    = pend_dl_ff;
                  last_in   = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_slot_in = 4'(rd_link);
               pend_dl_in   = rd_dl;
               cnt_in       = cnt_ff + 1'b1;
            end else begin
               strobe_in = 1'b1;
               if (pend_v_ff) begin
                  kind_in = RES_FIRED;
                  slot_in = pend_slot_ff;
                  dlo_in  = pend_dl_ff;
               end else begin
                  kind_in = RES_NONE;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      cnt_ff       <= cnt_in;
      pend_slot_ff <= pend_slot_in;
      pend_dl_ff   <= pend_dl_in;
      kind_ff      <= kind_in;
      slot_ff      <= slot_in;
      flag_ff      <= flag_in;
      dlo_ff       <= dlo_in;
      last_ff      <= last_in;
   end

   // List storage updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            dl_ff[i]  <= 64'sd0;
            nxt_ff[i] <= NIL;
         end
         head_ff[0] <= NIL;
         head_ff[1] <= NIL;
         linked_ff  <= '0;
         inlist_ff  <= '0;
      end else begin
         if (dl_we) begin
            dl_ff[sidx] <= cmd_ff.time_value;
         end
         if (nxa_we) begin
            nxt_ff[nxa_idx] <= nxa_d;
         end
         if (nxb_we) begin
            nxt_ff[nxb_idx] <= nxb_d;
         end
         if (hd_we) begin
            head_ff[hd_sel] <= hd_d;
         end
         if (lk_we) begin
            linked_ff[lk_idx] <= lk_val;
         end
         if (il_we) begin
            inlist_ff[sidx] <= il_val;
         end
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_fired_slot      = slot_ff;
   assign rsp_flag            = flag_ff;
   assign rsp_stored_deadline = dlo_ff;
   assign rsp_last            = last_ff;

endmodule

// ----- rtl/sorted_deadline_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: two deadline-sorted timer lists
// Slots are armed, deleted, queried, fired by tick and checked per list.
// ----------------------------------------------------------------------------
// Requests are taken while busy is low and wait in a two-entry queue; the
// engine behind it handles one request at a time. Results appear one per
// cycle with rsp_strobe high and must be taken in that cycle. Query, check,
// delete of an idle slot and unknown modes are answered from the dispatch state.
// Arm walks a list one entry a cycle, first to unlink a linked slot and then
// to insert it; delete of a linked slot walks to unlink it. A tick pops due
// heads of one list, the fired beats following back to back.
// Writes to slot_clock_mask are always ready and are to be made while idle.
module sorted_deadline_timer_queue #(
   parameter int SLOT_COUNT = sdtq_pkg::DEFAULT_SLOT_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_mode,
   input  logic [3:0]                      req_slot_id,
   input  logic                            req_clock_kind,
   input  logic signed [63:0]              req_time_value,
   output logic                            rsp_strobe,
   output logic [2:0]                      rsp_result_kind,
   output logic [3:0]                      rsp_fired_slot,
   output logic                            rsp_flag,
   output logic signed [63:0]              rsp_stored_deadline,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sdtq_pkg::MASK_WIDTH-1:0] csr_slot_clock_mask
);
   import sdtq_pkg::*;

   logic [MASK_WIDTH-1:0] mask_ff, mask_in;
   logic                  q_valid, q_pop;
   cmd_type               q_data;

   // Clock-kind mask register.
   assign csr_ready = 1'b1;
   assign mask_in   = (csr_valid && csr_ready) ? csr_slot_clock_mask : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   sdtq_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_slot_id    (req_slot_id),
      .req_clock_kind (req_clock_kind),
      .req_time_value (req_time_value),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop)
   );

   sdtq_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock               (clock),
      .reset               (reset),
      .slot_clock_mask     (mask_ff),
      .q_valid             (q_valid),
      .q_data              (q_data),
      .q_pop               (q_pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_fired_slot      (rsp_fired_slot),
      .rsp_flag            (rsp_flag),
      .rsp_stored_deadline (rsp_stored_deadline),
      .rsp_last            (rsp_last)
   );

endmodule
